>>> hdl/tgd_pkg.sv
package tgd_pkg;

    localparam int MAX_GLYPHS = 64;
    localparam int IDX_W      = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);
    localparam int ROWS       = 8;
    localparam int ROW_W      = 3;
    localparam int PIX        = 8;
    localparam int PIX_W      = 8;
    localparam int GLYPH_W    = ROWS * PIX;
    localparam int COLOUR_W   = 3;
    localparam int INDEX_W    = 6;
    localparam int CODE_W     = 8;
    localparam int MAX_COLOUR = 4;

    typedef enum logic [1:0] {
        STAT_MATCH      = 2'd0,
        STAT_NEW        = 2'd1,
        STAT_COLOUR_ERR = 2'd2,
        STAT_FULL       = 2'd3
    } status_t;

    typedef enum logic {
        S_ROWS,
        S_SEARCH
    } state_t;

    typedef struct packed {
        logic    clear_all;
        logic    row_load;
        logic    search;
        logic    finish;
        status_t result;
    } dp_cmd_t;

    typedef struct packed {
        logic row_last;
        logic cell_error;
        logic hit;
        logic exhausted;
        logic table_full;
    } dp_stat_t;

    typedef struct packed {
        logic [PIX-1:0]      rowbits;
        logic [COLOUR_W-1:0] colour;
        logic                err;
    } row_scan_t;

    function automatic row_scan_t scan_row(
        input logic [GLYPH_W-1:0]  pixels,
        input logic [COLOUR_W-1:0] seen_in
    );
        row_scan_t        r;
        logic [PIX_W-1:0] c;
        r.rowbits = '0;
        r.colour  = seen_in;
        r.err     = 1'b0;
        for (int i = 0; i < PIX; i++)
        begin
            c = pixels[i*PIX_W +: PIX_W];
            if (c != '0)
            begin
                if (c > PIX_W'(MAX_COLOUR))
                begin
                    r.err = 1'b1;
                end
                else
                begin
                    if (r.colour != c[COLOUR_W-1:0])
                    begin
                        if (r.colour != '0)
                        begin
                            r.err = 1'b1;
                        end
                        else
                        begin
                            r.colour = c[COLOUR_W-1:0];
                        end
                    end
                    r.rowbits[PIX-1-i] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/tgd_datapath.sv
module tgd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tgd_pkg::dp_cmd_t                  cmd,
    output tgd_pkg::dp_stat_t                 stat,
    input  logic [tgd_pkg::GLYPH_W-1:0]       pixels,
    output logic [1:0]                        status,
    output logic [tgd_pkg::CODE_W-1:0]        cell_code,
    output logic [tgd_pkg::INDEX_W-1:0]       glyph_index,
    output logic [tgd_pkg::COLOUR_W-1:0]      cell_colour,
    output logic [tgd_pkg::GLYPH_W-1:0]       glyph_bits
);
    import tgd_pkg::*;

    logic [GLYPH_W-1:0]  glyph_mem [MAX_GLYPHS];

    logic [ROW_W-1:0]    row_counter_reg, row_counter_next;
    logic [GLYPH_W-1:0]  cell_bitmap_reg, cell_bitmap_next;
    logic [COLOUR_W-1:0] seen_colour_reg, seen_colour_next;
    logic                cell_error_reg, cell_error_next;
    logic [CNT_W-1:0]    glyph_count_reg, glyph_count_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [GLYPH_W-1:0]  rdata_reg;

    logic [1:0]          status_reg;
    logic [CODE_W-1:0]   cell_code_reg;
    logic [INDEX_W-1:0]  glyph_index_reg;
    logic [COLOUR_W-1:0] cell_colour_reg;
    logic [GLYPH_W-1:0]  glyph_bits_reg;

    row_scan_t           scan;
    logic                issue;
    logic                append;
    logic [IDX_W-1:0]    res_idx;
    logic [ROW_W-1:0]    row_slot;
    logic [CODE_W-1:0]   res_code;

    assign scan     = scan_row(pixels, seen_colour_reg);
    assign issue    = cmd.search && (rd_ptr_reg < glyph_count_reg);
    assign append   = cmd.finish && (cmd.result == STAT_NEW);
    assign row_slot = ROW_W'(ROWS - 1) - row_counter_reg;
    assign res_idx  = (cmd.result == STAT_MATCH) ? cmp_idx_reg
                                                 : glyph_count_reg[IDX_W-1:0];
    assign res_code = {seen_colour_reg[1:0] + 2'd3, {(CODE_W-2){1'b0}}}
                      | CODE_W'(res_idx);

    always_comb
    begin
        row_counter_next = row_counter_reg;
        cell_bitmap_next = cell_bitmap_reg;
        seen_colour_next = seen_colour_reg;
        cell_error_next  = cell_error_reg;
        glyph_count_next = glyph_count_reg;
        if (cmd.clear_all)
        begin
            row_counter_next = '0;
            cell_bitmap_next = '0;
            seen_colour_next = '0;
            cell_error_next  = 1'b0;
            glyph_count_next = '0;
        end
        else if (cmd.row_load)
        begin
            row_counter_next = row_counter_reg + 1'b1;
            cell_bitmap_next = cell_bitmap_reg
                               | (GLYPH_W'(scan.rowbits) << {row_slot, 3'b000});
            seen_colour_next = scan.colour;
            cell_error_next  = cell_error_reg | scan.err;
        end
        else if (cmd.finish)
        begin
            row_counter_next = '0;
            cell_bitmap_next = '0;
            seen_colour_next = '0;
            cell_error_next  = 1'b0;
            if (append)
            begin
                glyph_count_next = glyph_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        cmp_valid_next = issue;
        if (cmd.clear_all || cmd.row_load)
        begin
            rd_ptr_next = '0;
        end
        else if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg <= '0;
            cell_bitmap_reg <= '0;
            seen_colour_reg <= '0;
            cell_error_reg  <= 1'b0;
            glyph_count_reg <= '0;
            rd_ptr_reg      <= '0;
            cmp_valid_reg   <= 1'b0;
        end
        else
        begin
            row_counter_reg <= row_counter_next;
            cell_bitmap_reg <= cell_bitmap_next;
            seen_colour_reg <= seen_colour_next;
            cell_error_reg  <= cell_error_next;
            glyph_count_reg <= glyph_count_next;
            rd_ptr_reg      <= rd_ptr_next;
            cmp_valid_reg   <= cmp_valid_next;
        end
    end

    // glyph table: one read and one write port
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rdata_reg <= glyph_mem[rd_ptr_reg[IDX_W-1:0]];
        end
        if (append)
        begin
            glyph_mem[glyph_count_reg[IDX_W-1:0]] <= cell_bitmap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_ptr_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.result;
            case (cmd.result)
                STAT_MATCH, STAT_NEW:
                begin
                    cell_code_reg   <= res_code;
                    glyph_index_reg <= INDEX_W'(res_idx);
                    cell_colour_reg <= seen_colour_reg;
                    glyph_bits_reg  <= cell_bitmap_reg;
                end
                STAT_FULL:
                begin
                    cell_code_reg   <= '0;
                    glyph_index_reg <= '0;
                    cell_colour_reg <= seen_colour_reg;
                    glyph_bits_reg  <= cell_bitmap_reg;
                end
                default:
                begin
                    cell_code_reg   <= '0;
                    glyph_index_reg <= '0;
                    cell_colour_reg <= '0;
                    glyph_bits_reg  <= '0;
                end
            endcase
        end
    end

    assign stat.row_last   = (row_counter_reg == ROW_W'(ROWS - 1));
    assign stat.cell_error = cell_error_reg;
    assign stat.hit        = cmp_valid_reg && (rdata_reg == cell_bitmap_reg);
    assign stat.exhausted  = (rd_ptr_reg == glyph_count_reg);
    assign stat.table_full = (glyph_count_reg == CNT_W'(MAX_GLYPHS));

    assign status      = status_reg;
    assign cell_code   = cell_code_reg;
    assign glyph_index = glyph_index_reg;
    assign cell_colour = cell_colour_reg;
    assign glyph_bits  = glyph_bits_reg;

endmodule

>>> hdl/tgd_ctrl.sv
module tgd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               kind,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output tgd_pkg::dp_cmd_t   cmd,
    input  tgd_pkg::dp_stat_t  stat
);
    import tgd_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ROWS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.result = STAT_MATCH;
        // a closing row waits until the result slot is free
        in_stall   = (state_reg != S_ROWS) || (out_valid_reg && stat.row_last);
        accept     = in_valid && !in_stall;
        case (state_reg)
            S_ROWS:
            begin
                if (accept)
                begin
                    if (!kind)
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    else
                    begin
                        cmd.row_load = 1'b1;
                        if (stat.row_last)
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.cell_error)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = STAT_COLOUR_ERR;
                end
                else if (stat.hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = STAT_MATCH;
                end
                else if (stat.exhausted)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = stat.table_full ? STAT_FULL : STAT_NEW;
                end
                if (cmd.finish)
                begin
                    state_next = S_ROWS;
                end
            end
            default:
            begin
                state_next = S_ROWS;
            end
        endcase
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/tile_glyph_dedup.sv
// tile_glyph_dedup: builds a glyph set from 8x8 cells and gives a screen code per cell
//
// input channel (in_valid / in_stall): one request per cell row, kind 1, rows 0..7 in
// order; kind 0 starts a new image, clears the glyph table and drops a partial cell.
// after the request that closes a cell, further requests are held off while the stored
// glyphs are compared one at a time through the single read port of the glyph table,
// which is scanned in index order until a hit or the glyph count is reached.
// output channel (out_valid / out_stall): one request per completed cell, registered,
// shown the cycle after the search ends; a colour error ends it before any compare.
// rows and start requests are still taken while a result waits; once seven rows of the
// next cell are in, any further request is held off until the pending result is taken.
// while the receiver stalls, the result holds and the block stalls at that row.
// reset clears the row counter, the cell state, the glyph count and the output valid;
// table contents stay undefined and are never read beyond the glyph count.
module tile_glyph_dedup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_0,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_1,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_2,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_3,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_4,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_5,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_6,
    input  logic [tgd_pkg::PIX_W-1:0]     pixel_7,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [tgd_pkg::CODE_W-1:0]    cell_code,
    output logic [tgd_pkg::INDEX_W-1:0]   glyph_index,
    output logic [tgd_pkg::COLOUR_W-1:0]  cell_colour,
    output logic [tgd_pkg::GLYPH_W-1:0]   glyph_bits
);
    import tgd_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [GLYPH_W-1:0] pixels;

    assign pixels = {pixel_7, pixel_6, pixel_5, pixel_4,
                     pixel_3, pixel_2, pixel_1, pixel_0};

    tgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    tgd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .pixels      (pixels),
        .status      (status),
        .cell_code   (cell_code),
        .glyph_index (glyph_index),
        .cell_colour (cell_colour),
        .glyph_bits  (glyph_bits)
    );

endmodule

>>> hdl/tgd_checker.sv
module tgd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          kind,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [tgd_pkg::CODE_W-1:0]    cell_code,
    input logic [tgd_pkg::INDEX_W-1:0]   glyph_index,
    input logic [tgd_pkg::COLOUR_W-1:0]  cell_colour,
    input logic [tgd_pkg::GLYPH_W-1:0]   glyph_bits
);
    import tgd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_COLOUR_ERR) |->
            (cell_code == '0) && (glyph_index == '0) && (cell_colour == '0)
            && (glyph_bits == '0))
        else $error("colour error result not cleared");

    a_code_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == STAT_MATCH) || (status == STAT_NEW)) |->
            (cell_code[5:0] == glyph_index)
            && (cell_code[7:6] == cell_colour[1:0] + 2'd3))
        else $error("screen code does not match index and colour");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL) |->
            (cell_code == '0) && (glyph_index == '0))
        else $error("table full result carries a code");

endmodule

bind tile_glyph_dedup tgd_checker u_tgd_checker (.*);
